// File: design/fbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbe_pkg
// Types, character constants and the per-byte encode function of the escape
// encoder.
// ----------------------------------------------------------------------------
package fbe_pkg;

  localparam int MAX_CHARS = 5;
  localparam int CNT_W     = 3;

  // encoding_mode codes
  localparam logic [1:0] MODE_BSL_ZERO = 2'd0;
  localparam logic [1:0] MODE_BSL      = 2'd1;
  localparam logic [1:0] MODE_PERCENT  = 2'd2;

  // escape_set codes
  localparam logic [1:0] SET_STRICT    = 2'd0;
  localparam logic [1:0] SET_CTRL_SP   = 2'd1;
  localparam logic [1:0] SET_CTRL      = 2'd2;

  // configuration register indexes
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_SET  = 1'b1;

  // command codes
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [7:0] CH_DASH    = 8'h2d;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_UNDER   = 8'h5f;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_NL      = 8'h0a;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LA      = 8'h61;

  typedef logic [MAX_CHARS-1:0][7:0] char_buf_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    char_buf_t        chars;
  } enc_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? (CH_ZERO + {4'd0, nib}) : (CH_LA + {4'd0, nib} - 8'd10);
  endfunction

  function automatic logic [7:0] oct_char(input logic [2:0] d);
    return CH_ZERO + {5'd0, d};
  endfunction

  function automatic logic needs_escape(input logic [7:0] b, input logic at_start,
                                        input logic [1:0] eset);
    logic ctrl;
    logic alnum;
    logic esc;
    ctrl  = (b < 8'd32) || (b == 8'd127);
    alnum = is_digit(b) || ((b >= 8'h61) && (b <= 8'h7a)) ||
            ((b >= 8'h41) && (b <= 8'h5a));
    unique case (eset)
      SET_CTRL:    esc = ctrl;
      SET_CTRL_SP: esc = ctrl || (b == CH_SPACE);
      default:     esc = !(alnum || b == CH_SLASH || b == CH_DOT ||
                           b == CH_UNDER || b == CH_DASH);
    endcase
    return esc || ((b == CH_DASH) && at_start);
  endfunction

  // Encode one held byte into 1 to 5 characters, first character in slot 0.
  function automatic enc_t encode_byte(input logic [7:0] b, input logic digit,
                                       input logic at_start, input logic [1:0] mode,
                                       input logic [1:0] eset);
    enc_t             e;
    logic             esc;
    logic [CNT_W-1:0] n;
    esc     = needs_escape(b, at_start, eset);
    e.chars = '0;
    e.cnt   = 3'd1;
    n       = '0;
    if (mode == MODE_PERCENT) begin
      if (esc || b == CH_PERCENT) begin
        if (b == 8'd0) begin
          e.chars[0] = CH_NL;
        end else begin
          e.chars[0] = CH_PERCENT;
          e.chars[1] = hex_char(b[7:4]);
          e.chars[2] = hex_char(b[3:0]);
          e.cnt      = 3'd3;
        end
      end else begin
        e.chars[0] = b;
      end
    end else begin
      e.chars[0] = CH_BSLASH;
      e.cnt      = 3'd2;
      unique case (b)
        8'd0: begin
          e.chars[0] = CH_NL;
          e.cnt      = 3'd1;
        end
        CH_BSLASH: e.chars[1] = CH_BSLASH;
        8'd7:      e.chars[1] = 8'h61; // a
        8'd8:      e.chars[1] = 8'h62; // b
        8'd12:     e.chars[1] = 8'h66; // f
        8'd10:     e.chars[1] = 8'h6e; // n
        8'd13:     e.chars[1] = 8'h72; // r
        8'd9:      e.chars[1] = 8'h74; // t
        8'd11:     e.chars[1] = 8'h76; // v
        default: begin
          if (!esc) begin
            e.chars[0] = b;
            e.cnt      = 3'd1;
          end else begin
            n = 3'd1;
            if (mode == MODE_BSL_ZERO) begin
              e.chars[n] = CH_ZERO;
              n          = n + 3'd1;
            end
            if (digit || b >= 8'd64) begin
              e.chars[n] = oct_char({1'b0, b[7:6]});
              n          = n + 3'd1;
            end
            e.chars[n] = oct_char(b[5:3]);
            n          = n + 3'd1;
            e.chars[n] = oct_char(b[2:0]);
            e.cnt      = n + 3'd1;
          end
        end
      endcase
    end
    return e;
  endfunction

endpackage
`default_nettype wire

// File: design/filename_byte_escape_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// filename_byte_escape_encoder_top
// Escapes a byte stream in percent-hex or backslash-octal form.
//
// Input channel in_*: in_tdata carries the raw byte, in_tuser the command
// (0 data byte, 1 end of record). Output channel out_*: out_tdata carries one
// encoded character, out_tlast marks the final character of an input item.
// Each data byte is held until the next item arrives (one byte lookahead),
// so its characters start in the cycle after the following item is accepted.
// An item producing n characters (n <= 5) keeps the output buffer busy until
// the last of them leaves, and the next item is taken in the cycle that last
// character leaves. Items with no result (first byte of a record, end with
// nothing held) leave the output buffer empty.
// Rate is set by the single five-entry output shift buffer.
// Reset empties the buffer, drops the held byte, marks the start of a path
// component and loads encoding_mode 2, escape_set 0. When the receiver
// stalls, the buffer holds and in_tready stays low while any character is
// waiting; with the buffer empty an item is still taken.
// ----------------------------------------------------------------------------
module filename_byte_escape_encoder_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tuser,   // [0] command
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_char
  output logic            out_tlast,  // last_of_run
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_addr,
  input  wire logic [1:0] cfg_wdata
);
  import fbe_pkg::*;

  logic [1:0]       mode_r;
  logic [1:0]       eset_r;
  logic             held_valid_r, held_valid_nxt;
  logic [7:0]       held_byte_r, held_byte_nxt;
  logic             at_start_r, at_start_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  char_buf_t        buf_r, buf_nxt;
  logic             in_acc;
  logic             out_acc;
  logic             digit;
  enc_t             enc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  assign in_tready  = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_tready);
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = buf_r[0];
  assign out_tlast  = (cnt_r == CNT_W'(1));

  assign digit = (in_tuser == CMD_DATA) && is_digit(in_tdata);
  assign enc   = encode_byte(held_byte_r, digit, at_start_r, mode_r, eset_r);

  always_comb begin
    held_valid_nxt = held_valid_r;
    held_byte_nxt  = held_byte_r;
    at_start_nxt   = at_start_r;
    cnt_nxt        = cnt_r;
    buf_nxt        = buf_r;
    if (in_acc) begin
      cnt_nxt = held_valid_r ? enc.cnt : '0;
      buf_nxt = enc.chars;
      if (in_tuser == CMD_DATA) begin
        if (held_valid_r) begin
          at_start_nxt = (held_byte_r == CH_SLASH);
        end
        held_byte_nxt  = in_tdata;
        held_valid_nxt = 1'b1;
      end else begin
        held_valid_nxt = 1'b0;
        held_byte_nxt  = '0;
        at_start_nxt   = 1'b1;
      end
    end else if (out_acc) begin
      // advance the buffer by one character
      cnt_nxt = cnt_r - CNT_W'(1);
      buf_nxt = {8'd0, buf_r[MAX_CHARS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_PERCENT;
      eset_r       <= SET_STRICT;
      held_valid_r <= 1'b0;
      held_byte_r  <= '0;
      at_start_r   <= 1'b1;
      cnt_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          CFG_MODE: mode_r <= cfg_wdata;
          CFG_SET:  eset_r <= cfg_wdata;
          default:  ;
        endcase
      end
      held_valid_r <= held_valid_nxt;
      held_byte_r  <= held_byte_nxt;
      at_start_r   <= at_start_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_CHARS))
    else $error("output buffer count out of range");

  a_no_take_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > CNT_W'(1)) |-> !in_tready)
    else $error("input taken while an earlier item still has characters pending");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == CMD_END) |=> (!held_valid_r && at_start_r))
    else $error("end of record did not reset the record state");

  a_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == CMD_DATA) |=> (held_valid_r && held_byte_r == $past(in_tdata)))
    else $error("data byte not held after acceptance");

  a_no_result_unheld: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !held_valid_r) |=> (cnt_r == '0))
    else $error("result produced with no byte held");

endmodule
`default_nettype wire

// File: tb/fbe_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbe_stream_checker
// Watches the byte and character streams of the escape encoder and the
// register writes. It keeps its own copy of the encoder state and works out
// the characters each accepted item must produce. Each accepted character is
// compared against the oldest one still waiting.
// ----------------------------------------------------------------------------
module fbe_stream_checker
  import fbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] command
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] out_char
  input  logic       out_tlast,
  input  logic       cfg_wr_en,
  input  logic       cfg_addr,
  input  logic [1:0] cfg_wdata,
  output int         fail_count,
  output int         outstanding
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  localparam logic [127:0] HEX_TAB = "0123456789abcdef";

  enc_char_t  chars_q[$];
  logic [1:0] mode_r;
  logic [1:0] set_r;
  logic       held_v;
  logic [7:0] held_b;
  logic       comp_start;
  enc_char_t  oldest;

  function automatic logic is_num(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic escape_hit(input logic [7:0] b);
    logic ctrl;
    logic alnum;
    ctrl  = (b < 8'd32) || (b == 8'd127);
    alnum = is_num(b) || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    if (b == CH_DASH && comp_start) return 1'b1;
    case (set_r)
      SET_CTRL:    return ctrl;
      SET_CTRL_SP: return ctrl || (b == CH_SPACE);
      default:     return !(alnum || b == CH_SLASH || b == CH_DOT ||
                            b == CH_UNDER || b == CH_DASH);
    endcase
  endfunction

  // Letter of the short backslash form, zero when the byte has none.
  function automatic logic [7:0] short_letter(input logic [7:0] b);
    case (b)
      8'd7:    return "a";
      8'd8:    return "b";
      8'd9:    return "t";
      8'd10:   return "n";
      8'd11:   return "v";
      8'd12:   return "f";
      8'd13:   return "r";
      default: return 8'd0;
    endcase
  endfunction

  task automatic queue_encoding(input logic [7:0] b, input logic digit);
    logic [7:0] seq[$];
    enc_char_t  c;
    if (mode_r == MODE_PERCENT) begin
      if (escape_hit(b) || b == CH_PERCENT) begin
        if (b == 8'd0) begin
          seq.push_back(CH_NL);
        end else begin
          seq.push_back(CH_PERCENT);
          seq.push_back(HEX_TAB[8*(15-b[7:4]) +: 8]);
          seq.push_back(HEX_TAB[8*(15-b[3:0]) +: 8]);
        end
      end else begin
        seq.push_back(b);
      end
    end else if (b == 8'd0) begin
      seq.push_back(CH_NL);
    end else if (b == CH_BSLASH) begin
      seq.push_back(CH_BSLASH);
      seq.push_back(CH_BSLASH);
    end else if (short_letter(b) != 8'd0) begin
      seq.push_back(CH_BSLASH);
      seq.push_back(short_letter(b));
    end else if (!escape_hit(b)) begin
      seq.push_back(b);
    end else begin
      seq.push_back(CH_BSLASH);
      if (mode_r == MODE_BSL_ZERO) seq.push_back(CH_ZERO);
      // a following digit forces the full three-digit octal form
      if (digit || b >= 8'd64) seq.push_back(CH_ZERO | {6'd0, b[7:6]});
      seq.push_back(CH_ZERO | {5'd0, b[5:3]});
      seq.push_back(CH_ZERO | {5'd0, b[2:0]});
    end
    foreach (seq[i]) begin
      c.ch   = seq[i];
      c.last = (i == seq.size() - 1);
      chars_q.push_back(c);
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [7:0] exp_ch,
                               input logic exp_last);
    if (fail_count < 10) begin
      $display("%s: expected char %h last %b, got char %h last %b",
               what, exp_ch, exp_last, out_tdata, out_tlast);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_r     = MODE_PERCENT;
      set_r      = SET_STRICT;
      held_v     = 1'b0;
      held_b     = 8'd0;
      comp_start = 1'b1;
      chars_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_addr == CFG_MODE) mode_r = cfg_wdata;
        else set_r = cfg_wdata;
      end
      // characters first: none of them can stem from an item taken at this edge
      if (out_tvalid && out_tready) begin
        if (chars_q.size() == 0) begin
          flag_mismatch("unexpected char", 8'hxx, 1'bx);
        end else begin
          oldest = chars_q.pop_front();
          if (out_tdata !== oldest.ch || out_tlast !== oldest.last)
            flag_mismatch("char mismatch", oldest.ch, oldest.last);
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_DATA) begin
          if (held_v) begin
            queue_encoding(held_b, is_num(in_tdata));
            comp_start = (held_b == CH_SLASH);
          end
          held_b = in_tdata;
          held_v = 1'b1;
        end else begin
          if (held_v) queue_encoding(held_b, 1'b0);
          held_v     = 1'b0;
          held_b     = 8'd0;
          comp_start = 1'b1;
        end
      end
      outstanding <= chars_q.size();
    end
  end

endmodule

// File: tb/filename_byte_escape_encoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filename_byte_escape_encoder_top_tb
// Feeds byte records through the escape encoder under every encoding mode and
// escape set, first a directed run over the named escapes, dashes, lookahead
// digits and empty records, then random records. The sender idles in bursts,
// the receiver stalls on its own pattern and once holds off long enough to
// back the encoder up. Checking is done by fbe_stream_checker.
// ----------------------------------------------------------------------------
module filename_byte_escape_encoder_top_tb;
  import fbe_pkg::*;

  localparam int         CYCLE_LIMIT = 200000;
  localparam int         HOLD_CYCLES = 90;
  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam logic [1:0] SET_SPARE   = 2'd3;
  localparam int         NUM_PHASES  = 6;
  localparam int         PHASE_ITEMS = 20;

  localparam logic [4:0][7:0] PCT_BYTES = {
    8'h7e, CH_DASH, 8'hab, 8'h00, CH_PERCENT
  };
  localparam int PCT_LEN = 5;
  // listed from the last byte down; the first byte sent is at index 0
  localparam logic [19:0][7:0] BSL_BYTES = {
    CH_NINE, CH_SPACE, CH_DASH, "a", CH_DASH, CH_SLASH, 8'h01, "5", 8'h1b, 8'hff,
    8'h0d, 8'h0c, 8'h0b, 8'h0a, 8'h09, 8'h08, 8'h07, CH_BSLASH, 8'h00, CH_DASH
  };
  localparam int BSL_LEN = 20;
  localparam logic [NUM_PHASES-1:0][1:0] PH_MODE = {
    MODE_PERCENT, MODE_BSL, MODE_PERCENT, MODE_BSL_ZERO, MODE_SPARE, MODE_BSL
  };
  localparam logic [NUM_PHASES-1:0][1:0] PH_SET = {
    SET_CTRL, SET_STRICT, SET_CTRL_SP, SET_SPARE, SET_CTRL, SET_CTRL_SP
  };

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'd0;
  logic       in_tuser   = CMD_DATA;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_wr_en  = 1'b0;
  logic       cfg_addr   = CFG_MODE;
  logic [1:0] cfg_wdata  = 2'd0;
  logic       hold_go    = 1'b0;
  int         fail_count;
  int         outstanding;
  int         cycle_cnt  = 0;
  int         burst_left = 0;

  filename_byte_escape_encoder_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  fbe_stream_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: stretches of varying readiness, one long hold-off on request.
  initial begin
    int  stretch;
    int  pct;
    bit  hold_done;
    hold_done = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_go && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      stretch = $urandom_range(4, 40);
      case ($urandom_range(0, 3))
        0:       pct = 100;
        1:       pct = 70;
        2:       pct = 40;
        default: pct = 10;
      endcase
      repeat (stretch) begin
        out_tready <= ($urandom_range(0, 99) < pct);
        @(posedge clk);
      end
    end
  end

  // Offer one item and return at the edge that takes it; idle between bursts.
  task automatic send_item(input logic cmd, input logic [7:0] b);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_end();
    send_item(CMD_END, 8'($urandom_range(0, 255)));
  endtask

  // Drain every expected character, then give the encoder time to settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic [1:0] eset);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= CFG_MODE;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_addr  <= CFG_SET;
    cfg_wdata <= eset;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 20) return CH_ZERO + 8'($urandom_range(0, 9));
    if (r < 35) begin
      k = $urandom_range(0, 25);
      return ($urandom_range(0, 1) == 1) ? "a" + 8'(k) : "A" + 8'(k);
    end
    if (r < 55) begin
      case ($urandom_range(0, 7))
        0:       return CH_SLASH;
        1:       return CH_DASH;
        2:       return CH_DOT;
        3:       return CH_UNDER;
        4:       return CH_PERCENT;
        5:       return CH_BSLASH;
        6:       return CH_SPACE;
        default: return 8'h00;
      endcase
    end
    if (r < 75) begin
      k = $urandom_range(0, 32);
      return (k == 32) ? 8'd127 : 8'(k);
    end
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int sent;
    int len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: percent hex, strict set
    for (int i = 0; i < PCT_LEN; i++) send_item(CMD_DATA, PCT_BYTES[i]);
    send_end();
    wait_idle();

    set_config(MODE_BSL_ZERO, SET_STRICT);
    for (int i = 0; i < BSL_LEN; i++) send_item(CMD_DATA, BSL_BYTES[i]);
    send_end();
    send_end();
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_config(PH_MODE[p], PH_SET[p]);
      if (p == 1) hold_go <= 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray end marker or a bare byte left for the next record
          if ($urandom_range(0, 1) == 1) send_end();
          else send_item(CMD_DATA, 8'($urandom_range(0, 255)));
          sent++;
        end else begin
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 20)
                                            : $urandom_range(1, 8);
          for (int i = 0; i < len; i++) send_item(CMD_DATA, pick_byte());
          send_end();
          sent += len + 1;
        end
      end
      send_end();
      wait_idle();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/fbe_pkg.sv
design/filename_byte_escape_encoder_top.sv
tb/fbe_stream_checker.sv
tb/filename_byte_escape_encoder_top_tb.sv
